// ----- sv/raluf_pkg.sv -----
// Package: widths, opcodes and beat types for the register ALU with NZCV flags.
package raluf_pkg;

   localparam int NUM_REGS   = 8;
   localparam int DATA_WIDTH = 32;

   // Field widths fixed by the interface.
   localparam int OP_W    = 4;
   localparam int REG_W   = 3;
   localparam int IMM_W   = 32;
   localparam int RESULT_W = 32;

   // Shift amount clamped to DATA_WIDTH + 1: every larger amount acts alike.
   localparam int SH_W = $clog2(DATA_WIDTH + 2);

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 4'd0,
      OP_AND = 4'd1,
      OP_ASR = 4'd2,
      OP_LSR = 4'd3,
      OP_LSL = 4'd4,
      OP_NOT = 4'd5,
      OP_ORR = 4'd6,
      OP_SUB = 4'd7,
      OP_XOR = 4'd8,
      OP_MOV = 4'd9
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]  req_type;
      logic             set_flags;
      logic [REG_W-1:0] dest_reg;
      logic [REG_W-1:0] first_src_reg;
      logic             second_is_imm;
      logic [REG_W-1:0] second_src_reg;
      logic [IMM_W-1:0] immediate;
   } req_beat_type;

   typedef struct packed {
      logic [REG_W-1:0]    written_reg;
      logic [RESULT_W-1:0] result_value;
      logic                flag_n;
      logic                flag_z;
      logic                flag_c;
      logic                flag_v;
   } rsp_beat_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

endpackage

// ----- sv/register_alu_with_flags_unit.sv -----
// Top level: register ALU with eight registers and NZCV status flags.
//
// Usage:
//  - req channel (req_valid/req_ready/req_beat) takes one decoded instruction
//    per beat: opcode, set_flags, destination, sources, immediate.
//  - rsp channel (rsp_valid/rsp_ready/rsp_beat) returns exactly one beat per
//    instruction, in order: the written register index, its new value and
//    the NZCV flags after the instruction.
//  - A beat accepted on req passes the input register, then the result
//    register, before it shows on rsp; one instruction per cycle while rsp
//    does not stall. Each instruction reads the register file and flags from
//    the input register, runs one pass through adder / logic / barrel shifter
//    and retires as it moves to the result register, so the following instruction always sees the updated state.
//  - Reset (synchronous, active high) clears all registers, the flags and
//    both pipeline valids.
//  - When the receiver stalls, the result register holds its beat and the
//    input register holds one more instruction; req_ready drops only when
//    both are full and rsp_ready is low.
//  - Undefined opcodes write nothing and leave the flags; the response then
//    carries the destination's current value.
module register_alu_with_flags_unit
   import raluf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_beat,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_beat
);

   // Input register stage.
   logic         req_valid_ff, req_valid_in;
   req_beat_type req_ff;

   // Architectural state.
   logic [DATA_WIDTH-1:0] regs_ff [NUM_REGS];
   flags_type             flags_ff, flags_in;

   // Result register stage.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_ff, rsp_in;

   logic advance;

   // Execute datapath signals.
   op_type                op;
   logic [DATA_WIDTH-1:0] opnd_a, opnd_b, reg_b, alu_r, dest_val;
   logic                  op_ok, dest_ok;
   logic                  nc, nv;
   logic [DATA_WIDTH:0]   sum_ext, dif_ext;
   logic [DATA_WIDTH:0]   lsl_ext, lsr_ext, asr_ext;
   logic [SH_W-1:0]       shamt;

   // Move the input stage forward whenever the result slot is free or drains.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   // Register reads: indexes at or above NUM_REGS read as zero.
   always_comb begin
      opnd_a   = '0;
      reg_b    = '0;
      dest_val = '0;
      dest_ok  = 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (int'(req_ff.first_src_reg) == i) begin
            opnd_a = regs_ff[i];
         end
         if (int'(req_ff.second_src_reg) == i) begin
            reg_b = regs_ff[i];
         end
         if (int'(req_ff.dest_reg) == i) begin
            dest_val = regs_ff[i];
            dest_ok  = 1'b1;
         end
      end
   end

   assign opnd_b = req_ff.second_is_imm ? DATA_WIDTH'(req_ff.immediate) : reg_b;
   assign op     = op_type'(req_ff.req_type);

   // Clamp the shift amount; anything above DATA_WIDTH behaves as DATA_WIDTH+1.
   assign shamt = (opnd_b > DATA_WIDTH'(DATA_WIDTH)) ? SH_W'(DATA_WIDTH + 1)
                                                     : SH_W'(opnd_b);

   // Extra bit catches the carry: last bit out for shifts, carry/no-borrow.
   assign sum_ext = {1'b0, opnd_a} + {1'b0, opnd_b};
   assign dif_ext = {1'b0, opnd_a} + {1'b0, ~opnd_b} + (DATA_WIDTH + 1)'(1);
   assign lsl_ext = {1'b0, opnd_a} << shamt;
   assign lsr_ext = {opnd_a, 1'b0} >> shamt;
   assign asr_ext = $signed({opnd_a, 1'b0}) >>> shamt;

   always_comb begin
      alu_r = '0;
      nc    = flags_ff.c;
      nv    = flags_ff.v;
      op_ok = 1'b1;
      case (op)
         OP_ADD: begin
            alu_r = sum_ext[DATA_WIDTH-1:0];
            nc    = sum_ext[DATA_WIDTH];
            nv    = (opnd_a[DATA_WIDTH-1] ^ alu_r[DATA_WIDTH-1])
                  & (opnd_b[DATA_WIDTH-1] ^ alu_r[DATA_WIDTH-1]);
         end
         OP_SUB: begin
            alu_r = dif_ext[DATA_WIDTH-1:0];
            nc    = dif_ext[DATA_WIDTH];
            nv    = (opnd_a[DATA_WIDTH-1] ^ opnd_b[DATA_WIDTH-1])
                  & (opnd_a[DATA_WIDTH-1] ^ alu_r[DATA_WIDTH-1]);
         end
         OP_AND: alu_r = opnd_a & opnd_b;
         OP_ORR: alu_r = opnd_a | opnd_b;
         OP_XOR: alu_r = opnd_a ^ opnd_b;
         OP_NOT: alu_r = ~opnd_b;
         OP_MOV: alu_r = opnd_b;
         OP_LSL: begin
            alu_r = lsl_ext[DATA_WIDTH-1:0];
            if (shamt == '0) begin
               alu_r = opnd_a;
            end else begin
               nc = lsl_ext[DATA_WIDTH];
            end
         end
         OP_LSR: begin
            alu_r = lsr_ext[DATA_WIDTH:1];
            if (shamt == '0) begin
               alu_r = opnd_a;
            end else begin
               nc = lsr_ext[0];
            end
         end
         OP_ASR: begin
            alu_r = asr_ext[DATA_WIDTH:1];
            if (shamt == '0) begin
               alu_r = opnd_a;
            end else begin
               nc = asr_ext[0];
            end
         end
         default: op_ok = 1'b0;
      endcase
   end

   // Next flags and response beat.
   always_comb begin
      flags_in = flags_ff;
      if (op_ok && req_ff.set_flags) begin
         flags_in.n = alu_r[DATA_WIDTH-1];
         flags_in.z = (alu_r == '0);
         flags_in.c = nc;
         flags_in.v = nv;
      end
      rsp_in.written_reg  = req_ff.dest_reg;
      rsp_in.result_value = !dest_ok ? '0
                          : op_ok    ? RESULT_W'(alu_r)
                                     : RESULT_W'(dest_val);
      rsp_in.flag_n = flags_in.n;
      rsp_in.flag_z = flags_in.z;
      rsp_in.flag_c = flags_in.c;
      rsp_in.flag_v = flags_in.v;
   end

   // Valid bookkeeping for both stages.
   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_valid && req_ready) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
            // Retire: write the destination; out-of-range indexes are dropped.
            for (int i = 0; i < NUM_REGS; i++) begin
               if (op_ok && int'(req_ff.dest_reg) == i) begin
                  regs_ff[i] <= alu_r;
               end
            end
         end
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_beat;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // The flags in a waiting response always match the architectural flags.
   a_rsp_flags_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.flag_n == flags_ff.n) && (rsp_ff.flag_z == flags_ff.z)
                    && (rsp_ff.flag_c == flags_ff.c) && (rsp_ff.flag_v == flags_ff.v))
      else $error("response flags differ from status flags");

   // Backpressure reaches req only when both stages are full and rsp stalls.
   a_ready_low_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> req_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("req_ready dropped with room in the pipeline");

   // An instruction without set_flags leaves the flags alone.
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && !req_ff.set_flags) |=> $stable(flags_ff))
      else $error("flags changed without set_flags");

   // A retiring instruction always lands in the result register.
   a_retire_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("retired instruction lost its response");

endmodule
